// ===== rtl/tbslp_pkg.sv =====
// Shared types and constants for the two-button short/long press detector.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package tbslp_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned LongWidth = 16;

    localparam logic [LongWidth-1:0] LongPressResetMs = 16'd1000;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_A    = 2'd1,
        HELD_B    = 2'd2
    } t_held_key;

    typedef enum logic [2:0] {
        VK_NONE  = 3'd0,
        VK_UP    = 3'd1,
        VK_DOWN  = 3'd2,
        VK_BACK  = 3'd3,
        VK_ENTER = 3'd4
    } t_vkey;

    typedef struct packed {
        logic                 button_a_down;
        logic                 button_b_down;
        logic [TimeWidth-1:0] time_ms;
        logic                 clear_request;
        logic                 consume;
    } t_poll;

endpackage

`default_nettype wire

// ===== rtl/tbslp_in_stage.sv =====
// Input register of the press detector: captures one poll per transfer.
// Depends on tbslp_pkg for the poll struct.
`default_nettype none

module tbslp_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_button_a_down,
    input  wire                 i_button_b_down,
    input  wire [31:0]          i_time_ms,
    input  wire                 i_clear_request,
    input  wire                 i_consume,
    input  wire                 i_advance,
    output logic                o_valid,
    output tbslp_pkg::t_poll    o_poll
);

    logic             r_valid;
    tbslp_pkg::t_poll r_poll;
    logic             w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_poll.button_a_down <= i_button_a_down;
            r_poll.button_b_down <= i_button_b_down;
            r_poll.time_ms       <= i_time_ms;
            r_poll.clear_request <= i_clear_request;
            r_poll.consume       <= i_consume;
        end
    end

    assign o_valid = r_valid;
    assign o_poll  = r_poll;

endmodule

`default_nettype wire

// ===== rtl/tbslp_press_logic.sv =====
// Press state, threshold register and per-poll decision logic of the detector.
// Depends on tbslp_pkg for the poll struct and the key enums.
`default_nettype none

module tbslp_press_logic (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire [tbslp_pkg::LongWidth-1:0]      i_cfg_wr_data,
    input  wire                                 i_fire,
    input  tbslp_pkg::t_poll                    i_poll,
    output tbslp_pkg::t_vkey                    o_key
);

    logic [tbslp_pkg::LongWidth-1:0] r_long_press_ms;
    tbslp_pkg::t_held_key            r_held_key;
    tbslp_pkg::t_held_key            n_held_key;
    logic [tbslp_pkg::TimeWidth-1:0] r_press_start;
    logic [tbslp_pkg::TimeWidth-1:0] n_press_start;
    logic                            r_long_done;
    logic                            n_long_done;
    logic                            r_wait_release;
    logic                            n_wait_release;
    tbslp_pkg::t_vkey                r_pending_key;
    tbslp_pkg::t_vkey                n_pending_key;

    tbslp_pkg::t_vkey                w_poll_pending;
    tbslp_pkg::t_held_key            w_now_key;
    logic [tbslp_pkg::TimeWidth-1:0] w_dur;
    logic                            w_reached;

    assign w_now_key = i_poll.button_a_down ? tbslp_pkg::HELD_A :
                       (i_poll.button_b_down ? tbslp_pkg::HELD_B : tbslp_pkg::HELD_NONE);
    assign w_dur     = i_poll.time_ms - r_press_start;
    assign w_reached = w_dur >= {{(tbslp_pkg::TimeWidth-tbslp_pkg::LongWidth){1'b0}},
                                 r_long_press_ms};

    always_comb begin
        n_held_key     = r_held_key;
        n_press_start  = r_press_start;
        n_long_done    = r_long_done;
        n_wait_release = r_wait_release;
        w_poll_pending = r_pending_key;
        if (i_poll.clear_request) begin
            n_held_key     = tbslp_pkg::HELD_NONE;
            n_press_start  = '0;
            n_long_done    = 1'b0;
            n_wait_release = 1'b1;
            w_poll_pending = tbslp_pkg::VK_NONE;
        end else if (r_wait_release) begin
            if (!i_poll.button_a_down && !i_poll.button_b_down) begin
                n_wait_release = 1'b0;
                n_held_key     = tbslp_pkg::HELD_NONE;
                n_press_start  = '0;
                n_long_done    = 1'b0;
            end
        end else if (w_now_key != tbslp_pkg::HELD_NONE) begin
            if (r_held_key == tbslp_pkg::HELD_NONE) begin
                n_held_key    = w_now_key;
                n_press_start = i_poll.time_ms;
                n_long_done   = 1'b0;
            end else if (w_reached && !r_long_done) begin
                n_long_done = 1'b1;
                case (r_held_key)
                    tbslp_pkg::HELD_A: w_poll_pending = tbslp_pkg::VK_BACK;
                    tbslp_pkg::HELD_B: w_poll_pending = tbslp_pkg::VK_ENTER;
                    default:           w_poll_pending = r_pending_key;
                endcase
            end
        end else if (r_held_key != tbslp_pkg::HELD_NONE) begin
            if (!w_reached && !r_long_done) begin
                case (r_held_key)
                    tbslp_pkg::HELD_A: w_poll_pending = tbslp_pkg::VK_UP;
                    tbslp_pkg::HELD_B: w_poll_pending = tbslp_pkg::VK_DOWN;
                    default:           w_poll_pending = r_pending_key;
                endcase
            end
            n_held_key    = tbslp_pkg::HELD_NONE;
            n_press_start = '0;
        end
        n_pending_key = i_poll.consume ? tbslp_pkg::VK_NONE : w_poll_pending;
    end

    always_comb begin
        o_key = i_poll.consume ? w_poll_pending : tbslp_pkg::VK_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= tbslp_pkg::LongPressResetMs;
        end else if (i_cfg_wr_en) begin
            r_long_press_ms <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key     <= tbslp_pkg::HELD_NONE;
            r_press_start  <= '0;
            r_long_done    <= 1'b0;
            r_wait_release <= 1'b0;
            r_pending_key  <= tbslp_pkg::VK_NONE;
        end else if (i_fire) begin
            r_held_key     <= n_held_key;
            r_press_start  <= n_press_start;
            r_long_done    <= n_long_done;
            r_wait_release <= n_wait_release;
            r_pending_key  <= n_pending_key;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tbslp_out_stage.sv =====
// Result register of the press detector: holds one key until it is transferred.
// Depends on tbslp_pkg for the key enum.
`default_nettype none

module tbslp_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  tbslp_pkg::t_vkey    i_key,
    input  wire                 i_stall,
    output logic                o_valid,
    output logic [2:0]          o_key,
    output logic                o_free
);

    logic             r_valid;
    tbslp_pkg::t_vkey r_key;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

`default_nettype wire

// ===== rtl/two_button_short_long_press_core.sv =====
// Top level of the two-button short/long press detector.
// Depends on tbslp_pkg, tbslp_in_stage, tbslp_press_logic and tbslp_out_stage.
//
// Each input transfer is one poll: two button levels, a millisecond timestamp,
// a clear flag and a consume flag. Every poll yields exactly one result transfer
// carrying o_virtual_key, which is the pending key when consume was set and zero
// otherwise.
// The poll is held in the input register, then the decision logic loads the result
// register, whose valid flag offers the result transfer; a receiver stall can hold
// the poll in the input register before the result register is loaded.
// Throughput is one poll per cycle while the receiver does not stall; the subtract
// and compare of the hold time against the threshold are combinational.
// The user must write the threshold register through i_cfg_wr_en and i_cfg_wr_data
// only while no poll is in flight; the block itself does not enforce this.
// Synchronous reset empties both registers, clears the press state and loads the
// threshold with 1000 ms.
// When the receiver stalls, the result holds; the input register still takes one
// more poll, then o_in_stall rises until the result is transferred.
`default_nettype none

module two_button_short_long_press_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [15:0]  i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_button_a_down,
    input  wire         i_button_b_down,
    input  wire [31:0]  i_time_ms,
    input  wire         i_clear_request,
    input  wire         i_consume,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_virtual_key
);

    tbslp_pkg::t_poll w_poll;
    tbslp_pkg::t_vkey w_key;
    logic             w_poll_valid;
    logic             w_out_free;
    logic             w_fire;

    assign w_fire = w_poll_valid && w_out_free;

    tbslp_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_button_a_down (i_button_a_down),
        .i_button_b_down (i_button_b_down),
        .i_time_ms       (i_time_ms),
        .i_clear_request (i_clear_request),
        .i_consume       (i_consume),
        .i_advance       (w_out_free),
        .o_valid         (w_poll_valid),
        .o_poll          (w_poll)
    );

    tbslp_press_logic u_press_logic (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_fire),
        .i_poll        (w_poll),
        .o_key         (w_key)
    );

    tbslp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_key   (w_key),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_key   (o_virtual_key),
        .o_free  (w_out_free)
    );

endmodule

`default_nettype wire

// ===== verif/tb_two_button_short_long_press_core.sv =====
// Testbench for two_button_short_long_press_core: directed table, then random press sequences
// and noise polls checked against a behavioral predictor. Depends on tbslp_pkg and the RTL in rtl/.
`timescale 1ns / 100ps

module tb_two_button_short_long_press_core;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned ItemsPerPhase = 117;
    localparam int unsigned HoldOffCycles = 80;

    typedef struct {
        tbslp_pkg::t_poll poll;
        bit               has_key;
        tbslp_pkg::t_vkey key;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_button_a_down = 1'b0;
    logic        i_button_b_down = 1'b0;
    logic [31:0] i_time_ms = '0;
    logic        i_clear_request = 1'b0;
    logic        i_consume = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_virtual_key;

    bit               drv_has_key = 1'b0;
    tbslp_pkg::t_vkey drv_key = tbslp_pkg::VK_NONE;

    // Predictor state, mirrors the block after reset.
    logic [15:0]           model_thr = tbslp_pkg::LongPressResetMs;
    tbslp_pkg::t_held_key  model_held = tbslp_pkg::HELD_NONE;
    logic [31:0]           model_start = '0;
    bit                    model_long_done = 1'b0;
    bit                    model_wait_release = 1'b0;
    tbslp_pkg::t_vkey      model_pending = tbslp_pkg::VK_NONE;

    tbslp_pkg::t_vkey expected_keys[$];
    tbslp_pkg::t_poll poll_q[$];
    t_dir_row         dir_tab[$];
    logic [31:0]      cur_ms = '0;
    int unsigned      tx_idle_pct = 18;
    int unsigned      rx_idle_pct = 63;
    int unsigned      rx_hold_req = 0;
    int unsigned      rx_hold_seen = 0;
    int unsigned      rx_hold_left = 0;
    int unsigned      fail_count = 0;
    int unsigned      cycle_count = 0;

    two_button_short_long_press_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_button_a_down (i_button_a_down),
        .i_button_b_down (i_button_b_down),
        .i_time_ms       (i_time_ms),
        .i_clear_request (i_clear_request),
        .i_consume       (i_consume),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_virtual_key   (o_virtual_key)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic tbslp_pkg::t_poll mk_poll(input logic a, input logic b,
                                                 input logic [31:0] t,
                                                 input logic clr, input logic cons);
        tbslp_pkg::t_poll p;
        p.button_a_down = a;
        p.button_b_down = b;
        p.time_ms       = t;
        p.clear_request = clr;
        p.consume       = cons;
        return p;
    endfunction

    function automatic tbslp_pkg::t_vkey predict_virtual_key(input tbslp_pkg::t_poll p);
        tbslp_pkg::t_held_key now_key;
        logic [31:0]          dur;
        tbslp_pkg::t_vkey     taken;
        taken = tbslp_pkg::VK_NONE;
        if (p.clear_request) begin
            model_held = tbslp_pkg::HELD_NONE;
            model_start = '0;
            model_long_done = 1'b0;
            model_wait_release = 1'b1;
            model_pending = tbslp_pkg::VK_NONE;
        end else if (model_wait_release) begin
            if (!p.button_a_down && !p.button_b_down) begin
                model_wait_release = 1'b0;
                model_held = tbslp_pkg::HELD_NONE;
                model_start = '0;
                model_long_done = 1'b0;
            end
        end else begin
            now_key = p.button_a_down ? tbslp_pkg::HELD_A :
                      (p.button_b_down ? tbslp_pkg::HELD_B : tbslp_pkg::HELD_NONE);
            dur = p.time_ms - model_start;
            if (now_key != tbslp_pkg::HELD_NONE) begin
                if (model_held == tbslp_pkg::HELD_NONE) begin
                    model_held = now_key;
                    model_start = p.time_ms;
                    model_long_done = 1'b0;
                end else if (dur >= {16'd0, model_thr} && !model_long_done) begin
                    model_long_done = 1'b1;
                    model_pending = (model_held == tbslp_pkg::HELD_A) ?
                                    tbslp_pkg::VK_BACK : tbslp_pkg::VK_ENTER;
                end
            end else if (model_held != tbslp_pkg::HELD_NONE) begin
                if (dur < {16'd0, model_thr} && !model_long_done) begin
                    model_pending = (model_held == tbslp_pkg::HELD_A) ?
                                    tbslp_pkg::VK_UP : tbslp_pkg::VK_DOWN;
                end
                model_held = tbslp_pkg::HELD_NONE;
                model_start = '0;
            end
        end
        if (p.consume) begin
            taken = model_pending;
            model_pending = tbslp_pkg::VK_NONE;
        end
        return taken;
    endfunction

    always @(posedge i_clk) begin
        tbslp_pkg::t_vkey want;
        tbslp_pkg::t_vkey predicted;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_keys.size() == 0) begin
                    $error("unexpected result transfer: virtual_key %0d", o_virtual_key);
                    fail_count++;
                end else begin
                    want = expected_keys.pop_front();
                    if (o_virtual_key !== 3'(want)) begin
                        $error("virtual_key mismatch: expected %0d, actual %0d",
                               want, o_virtual_key);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                model_thr = i_cfg_wr_data;
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = predict_virtual_key(mk_poll(i_button_a_down, i_button_b_down,
                                                        i_time_ms, i_clear_request, i_consume));
                expected_keys.push_back(drv_has_key ? drv_key : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HoldOffCycles;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_poll(input tbslp_pkg::t_poll p, input bit has_key,
                             input tbslp_pkg::t_vkey key);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_button_a_down <= p.button_a_down;
        i_button_b_down <= p.button_b_down;
        i_time_ms       <= p.time_ms;
        i_clear_request <= p.clear_request;
        i_consume       <= p.consume;
        drv_has_key     <= has_key;
        drv_key         <= key;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_keys.size() != 0);
    endtask

    task automatic write_threshold(input logic [15:0] thr);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_dir(input logic a, input logic b, input logic [31:0] t,
                           input logic clr, input logic cons, input bit has_key,
                           input tbslp_pkg::t_vkey key);
        t_dir_row row;
        row.poll = mk_poll(a, b, t, clr, cons);
        row.has_key = has_key;
        row.key = key;
        dir_tab.push_back(row);
    endtask

    function automatic logic rand_clear();
        return ($urandom_range(39) == 0);
    endfunction

    function automatic logic [31:0] pick_hold(input int unsigned thr);
        case ($urandom_range(7))
            0: return 32'd0;
            1: return thr - 1;
            2: return thr;
            3: return thr + 1;
            4: return $urandom_range(thr - 1);
            5: return thr + $urandom_range(thr);
            6: return $urandom_range(2 * thr);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_press_seq(input int unsigned thr);
        int unsigned n_idle;
        int unsigned n_held;
        int unsigned sel;
        int unsigned i;
        logic [31:0] hold_ms;
        logic [31:0] t0;
        bit          hold_at_end;
        logic        a;
        logic        b;
        n_idle = $urandom_range(2);
        for (i = 0; i < n_idle; i++) begin
            cur_ms += $urandom_range(thr);
            poll_q.push_back(mk_poll(1'b0, 1'b0, cur_ms, rand_clear(),
                                     1'($urandom_range(1))));
        end
        sel = $urandom_range(2);
        a = (sel != 1);
        b = (sel != 0);
        n_held = $urandom_range(4, 1);
        hold_ms = pick_hold(thr);
        hold_at_end = 1'($urandom_range(1));
        t0 = cur_ms;
        for (i = 0; i < n_held; i++) begin
            if (i > 0 && $urandom_range(3) == 0) begin
                sel = $urandom_range(2);
                a = (sel != 1);
                b = (sel != 0);
            end
            poll_q.push_back(mk_poll(a, b, t0 + 32'((longint'(hold_ms) * i) / n_held),
                                     rand_clear(), 1'($urandom_range(1))));
        end
        cur_ms = t0 + hold_ms;
        if (hold_at_end) begin
            poll_q.push_back(mk_poll(a, b, cur_ms, rand_clear(), 1'($urandom_range(1))));
            cur_ms += $urandom_range(thr);
        end
        poll_q.push_back(mk_poll(1'b0, 1'b0, cur_ms, rand_clear(), 1'($urandom_range(1))));
    endtask

    task automatic queue_noise();
        int unsigned      n;
        int unsigned      i;
        tbslp_pkg::t_poll p;
        n = $urandom_range(3, 1);
        for (i = 0; i < n; i++) begin
            p = mk_poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                        ($urandom_range(7) == 0), 1'($urandom_range(1)));
            poll_q.push_back(p);
        end
        if ($urandom_range(3) == 0) begin
            cur_ms = p.time_ms;
        end
    endtask

    task automatic run_random_phase(input logic [15:0] thr, input int unsigned tx_pct,
                                    input int unsigned rx_pct, input bit hold_off);
        int unsigned      sent;
        tbslp_pkg::t_poll p;
        write_threshold(thr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold_off) begin
            rx_hold_req++;
        end
        if ($urandom_range(3) == 0) begin
            cur_ms = 32'hFFFF_FFFF - $urandom_range(4 * thr);
        end else begin
            cur_ms = $urandom;
        end
        poll_q.delete();
        sent = 0;
        while (sent < ItemsPerPhase) begin
            if (poll_q.size() == 0) begin
                if ($urandom_range(4) == 0) begin
                    queue_noise();
                end else begin
                    queue_press_seq(thr);
                end
            end
            p = poll_q.pop_front();
            send_poll(p, 1'b0, tbslp_pkg::VK_NONE);
            sent++;
        end
    endtask

    initial begin
        logic [15:0] thr_list[9];
        int unsigned tx_pct;
        int unsigned rx_pct;
        int unsigned idx;

        // Directed table at the reset threshold of 1000 ms.
        add_dir(0, 0, 32'd0,           0, 1, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'd100,         0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd1099,        0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 1, 32'd2000,        0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 1, 32'd3000,        0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd3500,        0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'hFFFF_FF00,   0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 1, 32'h0000_02E7,   0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 1, 32'h0000_02E8,   0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'h0000_0400,   0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'd5000,        0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd7000,        0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 1, 32'd8000,        0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd8001,        0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'd9000,        0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd9010,        0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 1, 32'd10000,       0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 1, 32'd10500,       1, 1, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'd20000,       0, 1, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd20001,       0, 1, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'hFFFF_FFFF,   0, 0, 1, tbslp_pkg::VK_NONE);
        add_dir(1, 0, 32'h0000_03E7,   0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(1, 1, 32'h8000_0000,   0, 1, 0, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd0,           1, 1, 1, tbslp_pkg::VK_NONE);
        add_dir(0, 0, 32'd0,           0, 1, 1, tbslp_pkg::VK_NONE);

        thr_list = '{16'd1, 16'd65535, 16'd1000, 16'd7, 16'($urandom_range(65535, 1)),
                     16'd250, 16'd65534, 16'($urandom_range(65535, 1)), 16'd2};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_poll(dir_tab[i].poll, dir_tab[i].has_key, dir_tab[i].key);
        end

        for (idx = 0; idx < 9; idx++) begin
            if (idx < 3) begin
                tx_pct = 18;
                rx_pct = 63;
            end else if (idx < 6) begin
                tx_pct = 63;
                rx_pct = 18;
            end else begin
                tx_pct = 0;
                rx_pct = 0;
            end
            run_random_phase(thr_list[idx], tx_pct, rx_pct, (idx == 6));
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_keys.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tbslp_pkg.sv
rtl/tbslp_in_stage.sv
rtl/tbslp_press_logic.sv
rtl/tbslp_out_stage.sv
rtl/two_button_short_long_press_core.sv
verif/tb_two_button_short_long_press_core.sv
